FILE: rtl/glyph_alpha_pixel_compositor_macros.svh
// Assertion macros used by the compositor RTL.
`ifndef GLYPH_ALPHA_PIXEL_COMPOSITOR_MACROS_SVH
`define GLYPH_ALPHA_PIXEL_COMPOSITOR_MACROS_SVH
`ifndef SYNTHESIS
`define GAPC_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define GAPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GAPC_ASSERT(lbl, clk, rst, cond, msg)
`define GAPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/gapc_pkg.sv
package gapc_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = 32;
  localparam int COORD_W   = 16;
  localparam int CLIP_W    = 15;
  localparam int ALPHA_W   = 8;
  localparam int PROD_W    = 2 * CH_W;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 2 * COORD_W + ALPHA_W + PIX_W;

  localparam logic [ALPHA_W-1:0] ALPHA_EMPTY = 8'h00;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'hFF;
  localparam logic [CH_W-1:0]    TOP_BYTE    = 8'hFF;

  localparam logic MODE_OPAQUE      = 1'b0;
  localparam logic MODE_TRANSPARENT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR    = 3'd0,
    REG_BG_COLOR    = 3'd1,
    REG_BLEND_MODE  = 3'd2,
    REG_CLIP_LEFT   = 3'd3,
    REG_CLIP_TOP    = 3'd4,
    REG_CLIP_RIGHT  = 3'd5,
    REG_CLIP_BOTTOM = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PIX_SKIP,
    PIX_BG,
    PIX_FG,
    PIX_MIX
  } pix_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0]  fg_color;
    logic [PIX_W-1:0]  bg_color;
    logic              blend_mode;
    logic [CLIP_W-1:0] clip_left;
    logic [CLIP_W-1:0] clip_top;
    logic [CLIP_W-1:0] clip_right;
    logic [CLIP_W-1:0] clip_bottom;
  } cfg_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

FILE: rtl/glyph_alpha_pixel_compositor.sv
// Glyph alpha compositor: each input item is one glyph coverage pixel with its
// screen position, coverage and the framebuffer pixel now at that spot; each
// item yields exactly one result item, in order, saying whether to write the
// pixel (tuser) and with which word (tdata, zero when nothing is written).
// The datapath is a four-stage pipeline (clip and classify, channel multiply,
// channel sum, divide by 255 and select); a new item is accepted every cycle
// unless the pipeline is stalled; the output handshake alone stalls the
// pipeline, and empty stages fill up before the input stops. Registers are
// written through the cfg channel, which is always ready, and should be
// changed only while the pipeline is empty.
`include "glyph_alpha_pixel_compositor_macros.svh"

module glyph_alpha_pixel_compositor
  import gapc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // pixel_x[15:0], pixel_y[31:16], alpha[39:32], dst_pixel[71:40]
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_pixel[31:0]
  output logic [PIX_W-1:0]     m_tdata,
  // write_enable[0]
  output logic [0:0]           m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data
);

  cfg_t               cfg;
  stage_en_t          en;
  logic               en1;
  logic               v1, v2, v3, v4;
  pix_kind_t          kind1, kind2, kind3, kind4;
  logic [ALPHA_W-1:0] alpha1;
  logic [PIX_W-1:0]   base1;
  logic [PIX_W-1:0]   mix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color    <= '1;
      cfg.bg_color    <= '0;
      cfg.blend_mode  <= MODE_OPAQUE;
      cfg.clip_left   <= '0;
      cfg.clip_top    <= '0;
      cfg.clip_right  <= '0;
      cfg.clip_bottom <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FG_COLOR:    cfg.fg_color    <= cfg_data;
        REG_BG_COLOR:    cfg.bg_color    <= cfg_data;
        REG_BLEND_MODE:  cfg.blend_mode  <= cfg_data[0];
        REG_CLIP_LEFT:   cfg.clip_left   <= cfg_data[CLIP_W-1:0];
        REG_CLIP_TOP:    cfg.clip_top    <= cfg_data[CLIP_W-1:0];
        REG_CLIP_RIGHT:  cfg.clip_right  <= cfg_data[CLIP_W-1:0];
        REG_CLIP_BOTTOM: cfg.clip_bottom <= cfg_data[CLIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign en.s4    = !v4 || m_tready;
  assign en.s3    = !v3 || en.s4;
  assign en.s2    = !v2 || en.s3;
  assign en1      = !v1 || en.s2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_tvalid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.s4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      kind2 <= kind1;
    end
    if (en.s3) begin
      kind3 <= kind2;
    end
    if (en.s4) begin
      kind4 <= kind3;
    end
  end

  gapc_decode u_decode (
    .clk       (clk),
    .en        (en1),
    .cfg       (cfg),
    .pixel_x   ($signed(s_tdata[COORD_W-1:0])),
    .pixel_y   ($signed(s_tdata[2*COORD_W-1:COORD_W])),
    .alpha     (s_tdata[2*COORD_W +: ALPHA_W]),
    .dst_pixel (s_tdata[IN_W-1 -: PIX_W]),
    .kind      (kind1),
    .alpha_q   (alpha1),
    .base      (base1)
  );

  gapc_blend u_blend (
    .clk      (clk),
    .en       (en),
    .fg_color (cfg.fg_color),
    .base     (base1),
    .alpha    (alpha1),
    .mix      (mix)
  );

  assign m_tvalid   = v4;
  assign m_tuser[0] = (kind4 != PIX_SKIP);

  always_comb begin
    case (kind4)
      PIX_BG:  m_tdata = cfg.bg_color;
      PIX_FG:  m_tdata = cfg.fg_color;
      PIX_MIX: m_tdata = mix;
      default: m_tdata = '0;
    endcase
  end

  `GAPC_ASSERT(a_full_stalls_input, clk, rst, (v1 && v2 && v3 && v4 && !m_tready) |-> !s_tready, "full pipeline did not stall input")
  `GAPC_ASSERT_NEXT(a_accept_lands, clk, rst, s_tvalid && s_tready, v1, "accepted item lost at stage one")
  `GAPC_ASSERT_NEXT(a_stage3_holds, clk, rst, v3 && !en.s3, v3 && $stable(kind3), "stalled stage three changed")
  `GAPC_ASSERT(a_mix_top_byte, clk, rst, (v4 && kind4 == PIX_MIX) |-> (m_tdata[PIX_W-1 -: CH_W] == TOP_BYTE), "blended word lacks opaque top byte")

endmodule

FILE: rtl/gapc_decode.sv
module gapc_decode
  import gapc_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  cfg_t                      cfg,
  input  logic signed [COORD_W-1:0] pixel_x,
  input  logic signed [COORD_W-1:0] pixel_y,
  input  logic [ALPHA_W-1:0]        alpha,
  input  logic [PIX_W-1:0]          dst_pixel,
  output pix_kind_t                 kind,
  output logic [ALPHA_W-1:0]        alpha_q,
  output logic [PIX_W-1:0]          base
);

  logic      in_clip;
  pix_kind_t kind_next;

  always_comb begin
    in_clip = (pixel_x >= $signed({1'b0, cfg.clip_left}))  &&
              (pixel_x <  $signed({1'b0, cfg.clip_right})) &&
              (pixel_y >= $signed({1'b0, cfg.clip_top}))   &&
              (pixel_y <  $signed({1'b0, cfg.clip_bottom}));
    if (!in_clip) begin
      kind_next = PIX_SKIP;
    end else if (alpha == ALPHA_EMPTY) begin
      kind_next = (cfg.blend_mode == MODE_TRANSPARENT) ? PIX_SKIP : PIX_BG;
    end else if (alpha == ALPHA_FULL) begin
      kind_next = PIX_FG;
    end else begin
      kind_next = PIX_MIX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind    <= kind_next;
      alpha_q <= alpha;
      base    <= (cfg.blend_mode == MODE_TRANSPARENT) ? dst_pixel : cfg.bg_color;
    end
  end

endmodule

FILE: rtl/gapc_blend.sv
module gapc_blend
  import gapc_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  logic [PIX_W-1:0]   fg_color,
  input  logic [PIX_W-1:0]   base,
  input  logic [ALPHA_W-1:0] alpha,
  output logic [PIX_W-1:0]   mix
);

  logic [PROD_W-1:0] prod_f [NUM_CH];
  logic [PROD_W-1:0] prod_d [NUM_CH];
  logic [PROD_W-1:0] sum    [NUM_CH];
  logic [PROD_W:0]   rnd    [NUM_CH];
  logic [CH_W-1:0]   quot   [NUM_CH];
  logic [ALPHA_W-1:0] alpha_inv;

  assign alpha_inv = ALPHA_FULL - alpha;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < NUM_CH; i++) begin
        prod_f[i] <= {{CH_W{1'b0}}, fg_color[i*CH_W +: CH_W]} * {{CH_W{1'b0}}, alpha};
        prod_d[i] <= {{CH_W{1'b0}}, base[i*CH_W +: CH_W]} * {{CH_W{1'b0}}, alpha_inv};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sum[i] <= prod_f[i] + prod_d[i];
      end
    end
  end

  // Exact floor division by 255 for any sum up to 255 * 255.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      rnd[i]  = {1'b0, sum[i]} + {{(CH_W + 1){1'b0}}, sum[i][PROD_W-1:CH_W]}
                + {{PROD_W{1'b0}}, 1'b1};
      quot[i] = rnd[i][PROD_W-1:CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      mix[PIX_W-1 -: CH_W] <= TOP_BYTE;
      for (int i = 0; i < NUM_CH; i++) begin
        mix[i*CH_W +: CH_W] <= quot[i];
      end
    end
  end

endmodule
